// ===== design/sws_pkg.sv =====
`timescale 1ns / 1ps

package sws_pkg;

    // Window and field widths
    localparam int WINDOW_MAX = 32;
    localparam int SEQ_W      = 16;
    localparam int LEN_W      = 6;
    localparam int RUN_W      = $clog2(WINDOW_MAX + 1);
    localparam int TMO_W      = 8;
    localparam int STEP_W     = 4;

    // Input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_T_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_T_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_T_CAP   = 3'd4;

    // Datapath actions of one control word
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_START,
        ACT_SLIDE,
        ACT_COUNT,
        ACT_RESEND,
        ACT_EMIT,
        ACT_DONE
    } act_t;

    // Jump conditions
    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_BEAT,
        CND_IS_START,
        CND_IDLE,
        CND_IS_FINAL,
        CND_NO_SLIDE,
        CND_RUN_EMPTY,
        CND_NO_TIMEOUT
    } cond_t;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // Microprogram: jump to target when cond holds, else fall through.
    // Emit and done steps hold until their last beat is loaded.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            unique case (step)
                4'd0:    w = '{ACT_LATCH,  CND_NO_BEAT,    4'd0};
                4'd1:    w = '{ACT_NONE,   CND_IS_START,   4'd13};
                4'd2:    w = '{ACT_NONE,   CND_IDLE,       4'd0};
                4'd3:    w = '{ACT_NONE,   CND_IS_FINAL,   4'd15};
                4'd4:    w = '{ACT_NONE,   CND_NO_SLIDE,   4'd6};
                4'd5:    w = '{ACT_SLIDE,  CND_NEVER,      4'd0};
                4'd6:    w = '{ACT_COUNT,  CND_NEVER,      4'd0};
                4'd7:    w = '{ACT_NONE,   CND_RUN_EMPTY,  4'd9};
                4'd8:    w = '{ACT_EMIT,   CND_NEVER,      4'd0};
                4'd9:    w = '{ACT_NONE,   CND_NO_TIMEOUT, 4'd0};
                4'd10:   w = '{ACT_RESEND, CND_NEVER,      4'd0};
                4'd11:   w = '{ACT_NONE,   CND_RUN_EMPTY,  4'd0};
                4'd12:   w = '{ACT_EMIT,   CND_ALWAYS,     4'd0};
                4'd13:   w = '{ACT_START,  CND_NEVER,      4'd0};
                4'd14:   w = '{ACT_EMIT,   CND_ALWAYS,     4'd0};
                4'd15:   w = '{ACT_DONE,   CND_ALWAYS,     4'd0};
                default: w = '{ACT_NONE,   CND_ALWAYS,     4'd0};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== design/sliding_window_sender_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one result per cycle within a run while the output is not stalled;
// an item gives at most 64 results, in the order set by the microprogram steps.
// Only one item is in work at a time; in_ready is high only in the fetch step.
// Reset (rst_n low, asynchronous): no transfer running, window and wait count
// cleared, timeout limit 5, registers at total 1, length 32, timeout 5/5/30.

module sliding_window_sender_unit
    import sws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEQ_W-1:0]     cfg_data,
    // input items
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [SEQ_W-1:0]     ack_number,
    // result items
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SEQ_W-1:0]     seq_number,
    output logic                 is_retransmit,
    output logic                 transfer_done,
    output logic                 last_of_run
);

    // configuration registers
    logic [SEQ_W-1:0] total_reg;
    logic [LEN_W-1:0] length_reg;
    logic [TMO_W-1:0] t_start_reg;
    logic [TMO_W-1:0] t_step_reg;
    logic [TMO_W-1:0] t_cap_reg;

    // window state
    logic [SEQ_W-1:0] wfirst_reg;
    logic [SEQ_W-1:0] wlast_reg;
    logic [TMO_W-1:0] wait_reg;
    logic [TMO_W-1:0] limit_reg;
    logic             active_reg;

    // sequencer and run registers
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [1:0]        cmd_reg;
    logic [SEQ_W-1:0]  ack_reg;
    logic [SEQ_W-1:0]  cur_reg;
    logic [RUN_W-1:0]  cnt_reg;
    logic              rt_reg;
    logic              more_reg;
    logic              tmo_reg;

    // output register
    logic             ovalid_reg;
    logic [SEQ_W-1:0] oseq_reg;
    logic             ort_reg;
    logic             odone_reg;
    logic             olast_reg;

    ctrl_t ctrl;
    logic  load;
    logic  beat_load;
    logic  cond_true;
    logic  hold;

    // derived values
    logic [SEQ_W-1:0]   final_seq;
    logic [LEN_W-1:0]   len_eff;
    logic [SEQ_W-1:0]   len_m1;
    logic [SEQ_W-1:0]   start_last;
    logic [SEQ_W-1:0]   slide_first;
    logic [SEQ_W:0]     slide_sum;
    logic [SEQ_W-1:0]   slide_last;
    logic [SEQ_W-1:0]   slide_gap;
    logic [RUN_W-1:0]   slide_cnt;
    logic [SEQ_W:0]     span;
    logic [RUN_W-1:0]   resend_cnt;
    logic [TMO_W:0]     grown;
    logic [TMO_W-1:0]   limit_new;
    logic [TMO_W-1:0]   wait_inc;
    logic               in_window;

    assign cfg_ready = 1'b1;
    assign ctrl      = ucode(step_reg);
    assign in_ready  = (ctrl.act == ACT_LATCH);
    assign load      = !ovalid_reg || out_ready;
    assign beat_load = load && ((ctrl.act == ACT_EMIT) || (ctrl.act == ACT_DONE));

    always_comb
    begin
        final_seq = (total_reg == '0) ? '0 : total_reg - 1'b1;
        if (length_reg == '0)
            len_eff = LEN_W'(1);
        else if (length_reg > LEN_W'(WINDOW_MAX))
            len_eff = LEN_W'(WINDOW_MAX);
        else
            len_eff = length_reg;
        len_m1 = SEQ_W'(len_eff - 1'b1);

        // window on a start beat
        start_last = (len_m1 > final_seq) ? final_seq : len_m1;

        // window after an in-window ack
        in_window   = (ack_reg >= wfirst_reg) && (ack_reg <= wlast_reg);
        slide_first = ack_reg + 1'b1;
        slide_sum   = {1'b0, slide_first} + {1'b0, len_m1};
        slide_last  = (slide_sum > {1'b0, final_seq}) ? final_seq : slide_sum[SEQ_W-1:0];
        slide_gap   = slide_last - wlast_reg;
        if (slide_last <= wlast_reg)
            slide_cnt = '0;
        else if (slide_gap > SEQ_W'(WINDOW_MAX))
            slide_cnt = RUN_W'(WINDOW_MAX);
        else
            slide_cnt = slide_gap[RUN_W-1:0];

        // whole-window resend
        span = {1'b0, wlast_reg - wfirst_reg} + 1'b1;
        if (wlast_reg < wfirst_reg)
            resend_cnt = '0;
        else if (span > (SEQ_W+1)'(WINDOW_MAX))
            resend_cnt = RUN_W'(WINDOW_MAX);
        else
            resend_cnt = span[RUN_W-1:0];

        grown     = {1'b0, limit_reg} + {1'b0, t_step_reg};
        limit_new = (grown > {1'b0, t_cap_reg}) ? t_cap_reg : grown[TMO_W-1:0];
        wait_inc  = (wait_reg == '1) ? wait_reg : wait_reg + 1'b1;
    end

    // evaluate jump condition
    always_comb
    begin
        case (ctrl.cond)
            CND_ALWAYS:     cond_true = 1'b1;
            CND_NO_BEAT:    cond_true = !in_valid;
            CND_IS_START:   cond_true = (cmd_reg == CMD_START);
            CND_IDLE:       cond_true = !active_reg;
            CND_IS_FINAL:   cond_true = (cmd_reg == CMD_ACK) && (ack_reg == final_seq);
            CND_NO_SLIDE:   cond_true = !((cmd_reg == CMD_ACK) && in_window);
            CND_RUN_EMPTY:  cond_true = (cnt_reg == '0);
            CND_NO_TIMEOUT: cond_true = !tmo_reg;
            default:        cond_true = 1'b0;
        endcase
    end

    // next step: hold on output steps until their beat is loaded
    always_comb
    begin
        unique case (ctrl.act)
            ACT_EMIT: hold = !(load && (cnt_reg == RUN_W'(1)));
            ACT_DONE: hold = !load;
            default:  hold = 1'b0;
        endcase
        if (hold)
            step_next = step_reg;
        else if (cond_true)
            step_next = ctrl.target;
        else
            step_next = step_reg + 1'b1;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= SEQ_W'(1);
            length_reg  <= LEN_W'(WINDOW_MAX);
            t_start_reg <= TMO_W'(5);
            t_step_reg  <= TMO_W'(5);
            t_cap_reg   <= TMO_W'(30);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOTAL:   total_reg   <= cfg_data;
                CFG_LENGTH:  length_reg  <= cfg_data[LEN_W-1:0];
                CFG_T_START: t_start_reg <= cfg_data[TMO_W-1:0];
                CFG_T_STEP:  t_step_reg  <= cfg_data[TMO_W-1:0];
                CFG_T_CAP:   t_cap_reg   <= cfg_data[TMO_W-1:0];
                default:     ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            wfirst_reg <= '0;
            wlast_reg  <= '0;
            wait_reg   <= '0;
            limit_reg  <= TMO_W'(5);
            active_reg <= 1'b0;
            cmd_reg    <= '0;
            ack_reg    <= '0;
            cur_reg    <= '0;
            cnt_reg    <= '0;
            rt_reg     <= 1'b0;
            more_reg   <= 1'b0;
            tmo_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            oseq_reg   <= '0;
            ort_reg    <= 1'b0;
            odone_reg  <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            // drop the output beat once taken, unless a new one replaces it
            if (out_ready && !beat_load)
                ovalid_reg <= 1'b0;

            case (ctrl.act)
                ACT_LATCH:
                begin
                    if (in_valid)
                    begin
                        cmd_reg  <= cmd;
                        ack_reg  <= ack_number;
                        cnt_reg  <= '0;
                        more_reg <= 1'b0;
                        tmo_reg  <= 1'b0;
                    end
                end
                ACT_START:
                begin
                    wfirst_reg <= '0;
                    wlast_reg  <= start_last;
                    wait_reg   <= '0;
                    limit_reg  <= t_start_reg;
                    active_reg <= 1'b1;
                    cur_reg    <= '0;
                    cnt_reg    <= start_last[RUN_W-1:0] + 1'b1;
                    rt_reg     <= 1'b0;
                    more_reg   <= 1'b0;
                end
                ACT_SLIDE:
                begin
                    wfirst_reg <= slide_first;
                    wlast_reg  <= slide_last;
                    wait_reg   <= '0;
                    cur_reg    <= wlast_reg + 1'b1;
                    cnt_reg    <= slide_cnt;
                    rt_reg     <= 1'b0;
                end
                ACT_COUNT:
                begin
                    // a resend follows the slide run when it will send anything
                    wait_reg <= wait_inc;
                    tmo_reg  <= (wait_inc > limit_reg);
                    more_reg <= (wait_inc > limit_reg) && (wlast_reg >= wfirst_reg);
                end
                ACT_RESEND:
                begin
                    wait_reg  <= '0;
                    limit_reg <= limit_new;
                    cur_reg   <= wfirst_reg;
                    cnt_reg   <= resend_cnt;
                    rt_reg    <= 1'b1;
                    more_reg  <= 1'b0;
                end
                ACT_EMIT:
                begin
                    if (load)
                    begin
                        ovalid_reg <= 1'b1;
                        oseq_reg   <= cur_reg;
                        ort_reg    <= rt_reg;
                        odone_reg  <= 1'b0;
                        olast_reg  <= (cnt_reg == RUN_W'(1)) && !more_reg;
                        cur_reg    <= cur_reg + 1'b1;
                        cnt_reg    <= cnt_reg - 1'b1;
                    end
                end
                ACT_DONE:
                begin
                    if (load)
                    begin
                        ovalid_reg <= 1'b1;
                        oseq_reg   <= '0;
                        ort_reg    <= 1'b0;
                        odone_reg  <= 1'b1;
                        olast_reg  <= 1'b1;
                        active_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid     = ovalid_reg;
    assign seq_number    = oseq_reg;
    assign is_retransmit = ort_reg;
    assign transfer_done = odone_reg;
    assign last_of_run   = olast_reg;

endmodule

// ===== design/sws_checker.sv =====
`timescale 1ns / 1ps

module sws_checker
    import sws_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [SEQ_W-1:0]     cfg_data,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [1:0]           cmd,
    input logic [SEQ_W-1:0]     ack_number,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [SEQ_W-1:0]     seq_number,
    input logic                 is_retransmit,
    input logic                 transfer_done,
    input logic                 last_of_run
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seq_number)
            && $stable(is_retransmit) && $stable(transfer_done) && $stable(last_of_run))
        else $error("stalled result beat changed");

    // a done beat ends its run and carries no send
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transfer_done |-> last_of_run && !is_retransmit
            && (seq_number == '0))
        else $error("done beat malformed");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration beat refused");

endmodule

bind sliding_window_sender_unit sws_checker u_sws_checker (.*);

// ===== tb/tb_sliding_window_sender_unit.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_sender_unit;
    import sws_pkg::*;

    // Commands and register indexes that the package leaves unnamed
    localparam logic [1:0]           CMD_OTHER    = 2'd2;
    localparam logic [1:0]           CMD_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 16;
    localparam int STUCK_LIMIT   = 2000;
    localparam int RUN_LIMIT     = 1000000;

    typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_kind_t;

    // How the ACK number of a message is chosen when its beat is offered
    typedef enum logic [2:0] {
        AIM_RAW,
        AIM_IN_WINDOW,
        AIM_WIN_LAST,
        AIM_FINAL,
        AIM_BELOW
    } ack_aim_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_THROTTLE, SINK_CHOKE} sink_mode_t;

    typedef struct packed {
        job_kind_t            kind;
        logic [1:0]           cmd;
        logic [CFG_IDX_W-1:0] index;
        logic [SEQ_W-1:0]     value;
        ack_aim_t             aim;
    } job_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             retx;
        logic             done;
        logic             last;
    } send_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [SEQ_W-1:0]     cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [1:0]           cmd           = CMD_START;
    logic [SEQ_W-1:0]     ack_number    = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [SEQ_W-1:0]     seq_number;
    logic                 is_retransmit;
    logic                 transfer_done;
    logic                 last_of_run;

    // Register copies
    logic [SEQ_W-1:0] reg_total   = 16'd1;
    logic [LEN_W-1:0] reg_length  = 6'd32;
    logic [TMO_W-1:0] reg_t_start = 8'd5;
    logic [TMO_W-1:0] reg_t_step  = 8'd5;
    logic [TMO_W-1:0] reg_t_cap   = 8'd30;

    // Sender state
    logic [SEQ_W-1:0] win_first = '0;
    logic [SEQ_W-1:0] win_last  = '0;
    int unsigned      idle_msgs = 0;
    logic [TMO_W-1:0] tmo_limit = 8'd5;
    logic             xfer_open = 1'b0;

    job_t  jobs[$];
    send_t sends_due[$];

    int items_planned  = 0;
    int phase_count    = 0;
    int items_offered  = 0;
    int items_taken    = 0;
    int cfg_offered    = 0;
    int cfg_taken      = 0;
    int results_seen   = 0;
    int transfers_done = 0;
    int resend_runs    = 0;
    int error_count    = 0;

    int burst_left  = 0;
    int gap_left    = 0;
    int settle_cnt  = 0;
    int mode_left   = 0;
    int mode_tick   = 0;
    int stuck_count = 0;
    int run_count   = 0;
    sink_mode_t sink_mode = SINK_OPEN;

    sliding_window_sender_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .ack_number    (ack_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seq_number    (seq_number),
        .is_retransmit (is_retransmit),
        .transfer_done (transfer_done),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned final_seq_now();
        return (reg_total == 0) ? 0 : reg_total - 1;
    endfunction

    // Queue sends lo..hi, at most one window's worth
    task automatic queue_run(input int unsigned lo, input int unsigned hi, input logic retx);
        int unsigned s;
        if (hi >= lo)
        begin
            for (s = lo; s <= hi && s - lo < WINDOW_MAX; s++)
                sends_due.push_back('{seq: SEQ_W'(s), retx: retx, done: 1'b0, last: 1'b0});
        end
    endtask

    // Work out the sends that one accepted message causes
    task automatic sender_step(input logic [1:0] c, input logic [SEQ_W-1:0] ack);
        int unsigned fin;
        int unsigned len;
        int unsigned old_last;
        int unsigned nf;
        int unsigned nl;
        int unsigned grown;
        int          base;
        send_t       tail;
        base = sends_due.size();
        fin  = final_seq_now();
        len  = (reg_length == 0) ? 1 : (reg_length > WINDOW_MAX) ? WINDOW_MAX : reg_length;
        if (c == CMD_START)
        begin
            win_first = '0;
            win_last  = (len - 1 > fin) ? SEQ_W'(fin) : SEQ_W'(len - 1);
            idle_msgs = 0;
            tmo_limit = reg_t_start;
            xfer_open = 1'b1;
            queue_run(0, win_last, 1'b0);
        end
        else if (xfer_open)
        begin
            if (c == CMD_ACK && ack == fin)
            begin
                // final packet acknowledged: report and go idle
                xfer_open = 1'b0;
                transfers_done++;
                sends_due.push_back('{seq: '0, retx: 1'b0, done: 1'b1, last: 1'b0});
            end
            else
            begin
                if (c == CMD_ACK && ack >= win_first && ack <= win_last)
                begin
                    // slide past the ACK, send only what lies beyond the old end
                    old_last  = win_last;
                    nf        = (ack + 1) & 32'hFFFF;
                    nl        = nf + len - 1;
                    if (nl > fin)
                        nl = fin;
                    win_first = SEQ_W'(nf);
                    win_last  = SEQ_W'(nl);
                    if (win_last > old_last)
                        queue_run(old_last + 1, win_last, 1'b0);
                    idle_msgs = 0;
                end
                if (idle_msgs < 255)
                    idle_msgs++;
                if (idle_msgs > tmo_limit)
                begin
                    // timeout: resend the whole window and grow the limit
                    grown = tmo_limit + reg_t_step;
                    queue_run(win_first, win_last, 1'b1);
                    idle_msgs = 0;
                    tmo_limit = (grown > reg_t_cap) ? reg_t_cap : TMO_W'(grown);
                    resend_runs++;
                end
            end
        end
        // mark the closing send of this message
        if (sends_due.size() > base)
        begin
            tail      = sends_due.pop_back();
            tail.last = 1'b1;
            sends_due.push_back(tail);
        end
    endtask

    function automatic logic [SEQ_W-1:0] aim_ack(input job_t j);
        case (j.aim)
            AIM_IN_WINDOW: return (win_last >= win_first) ?
                                  SEQ_W'($urandom_range(win_first, win_last)) : j.value;
            AIM_WIN_LAST:  return win_last;
            AIM_FINAL:     return SEQ_W'(final_seq_now());
            AIM_BELOW:     return (win_first != 0) ? win_first - 1'b1 : j.value;
            default:       return j.value;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want_v,
                               input logic [SEQ_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    task automatic add_item(input logic [1:0] c, input logic [SEQ_W-1:0] v, input ack_aim_t a);
        jobs.push_back('{kind: JOB_ITEM, cmd: c, index: '0, value: v, aim: a});
        items_planned++;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SEQ_W-1:0] v);
        jobs.push_back('{kind: JOB_CFG, cmd: CMD_START, index: idx, value: v, aim: AIM_RAW});
    endtask

    task automatic add_drain();
        jobs.push_back('{kind: JOB_DRAIN, cmd: CMD_START, index: '0, value: '0, aim: AIM_RAW});
        phase_count++;
    endtask

    // Monitor: check sends, track register writes, predict accepted messages
    always @(posedge clk)
    begin : monitor
        send_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (sends_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected beat, expected none, got seq %0d rt %0b done %0b last %0b",
                             $time, seq_number, is_retransmit, transfer_done, last_of_run);
                end
                else
                begin
                    want = sends_due.pop_front();
                    check_field("seq_number", want.seq, seq_number);
                    check_field("is_retransmit", SEQ_W'(want.retx), SEQ_W'(is_retransmit));
                    check_field("transfer_done", SEQ_W'(want.done), SEQ_W'(transfer_done));
                    check_field("last_of_run", SEQ_W'(want.last), SEQ_W'(last_of_run));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TOTAL:   reg_total   = cfg_data;
                    CFG_LENGTH:  reg_length  = cfg_data[LEN_W-1:0];
                    CFG_T_START: reg_t_start = cfg_data[TMO_W-1:0];
                    CFG_T_STEP:  reg_t_step  = cfg_data[TMO_W-1:0];
                    CFG_T_CAP:   reg_t_cap   = cfg_data[TMO_W-1:0];
                    default:     ;
                endcase
                cfg_taken++;
            end
            if (in_valid && in_ready)
            begin
                sender_step(cmd, ack_number);
                items_taken++;
            end
        end
    end

    // Driver: offer jobs in bursts, hold each beat until taken
    always @(negedge clk)
    begin : driver
        job_t job;
        logic nxt_in;
        logic nxt_cfg;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nxt_in  = in_valid && (items_taken != items_offered);
            nxt_cfg = cfg_valid && (cfg_taken != cfg_offered);
            if (!nxt_in && !nxt_cfg)
            begin
                if (sends_due.size() == 0)
                    settle_cnt++;
                else
                    settle_cnt = 0;
                if (gap_left > 0)
                    gap_left--;
                else if (jobs.size() > 0)
                begin
                    job = jobs[0];
                    case (job.kind)
                        JOB_DRAIN:
                        begin
                            // wait for every send, then let the block settle
                            if (settle_cnt >= SETTLE_CYCLES)
                                void'(jobs.pop_front());
                        end
                        JOB_CFG:
                        begin
                            cfg_index <= job.index;
                            cfg_data  <= job.value;
                            nxt_cfg = 1'b1;
                            cfg_offered++;
                            void'(jobs.pop_front());
                        end
                        default:
                        begin
                            cmd        <= job.cmd;
                            ack_number <= aim_ack(job);
                            nxt_in = 1'b1;
                            items_offered++;
                            settle_cnt = 0;
                            void'(jobs.pop_front());
                            if (burst_left > 1)
                                burst_left--;
                            else
                            begin
                                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                                        : $urandom_range(1, 12);
                                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                            end
                        end
                    endcase
                end
            end
            in_valid  <= nxt_in;
            cfg_valid <= nxt_cfg;
        end
    end

    // Receiver: stall on a pattern that is picked anew at random
    always @(negedge clk)
    begin : receiver
        if (mode_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
            mode_tick = 0;
        end
        mode_left--;
        mode_tick++;
        case (sink_mode)
            SINK_OPEN:     out_ready <= 1'b1;
            SINK_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
            SINK_THROTTLE: out_ready <= (mode_tick % 3 == 0);
            default:       out_ready <= (mode_tick % 9 == 0);
        endcase
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stuck_count = 0;
            else
                stuck_count++;
            run_count++;
            if (stuck_count >= STUCK_LIMIT || run_count >= RUN_LIMIT)
            begin
                $display("%0t ns: timeout, %0d sends still due", $time, sends_due.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          roll;
        int          span;
        int          k;
        int          directed_items;
        logic        ended;
        logic [15:0] v;

        // idle messages, then the smallest transfer at reset settings
        add_item(CMD_ACK, 16'h0000, AIM_RAW);
        add_item(CMD_OTHER, 16'h5A5A, AIM_RAW);
        add_item(CMD_SPARE, 16'hFFFF, AIM_RAW);
        add_item(CMD_START, 16'h0000, AIM_RAW);
        add_item(CMD_ACK, 16'h0000, AIM_RAW);

        // zero total and length, instant timeouts, zero growth
        add_drain();
        add_cfg(CFG_TOTAL, 16'h0000);
        add_cfg(CFG_LENGTH, 16'h0000);
        add_cfg(CFG_T_START, 16'h0000);
        add_cfg(CFG_T_STEP, 16'h0000);
        add_cfg(CFG_T_CAP, 16'h0000);
        add_item(CMD_START, 16'h0000, AIM_RAW);
        add_item(CMD_OTHER, 16'h0000, AIM_RAW);
        add_item(CMD_SPARE, 16'h0000, AIM_RAW);
        add_item(CMD_ACK, 16'h0000, AIM_RAW);

        // all-ones registers: clipped length, no timeout, ACKs either side
        add_drain();
        add_cfg(CFG_TOTAL, 16'hFFFF);
        add_cfg(CFG_LENGTH, 16'hFFFF);
        add_cfg(CFG_T_START, 16'hFFFF);
        add_cfg(CFG_T_STEP, 16'hFFFF);
        add_cfg(CFG_T_CAP, 16'hFFFF);
        add_cfg(CFG_SPARE_HI, 16'hFFFF);
        add_item(CMD_START, 16'h0000, AIM_RAW);
        add_item(CMD_ACK, 16'd31, AIM_RAW);
        add_item(CMD_ACK, 16'hFFFF, AIM_RAW);
        add_item(CMD_ACK, 16'h0000, AIM_RAW);
        add_item(CMD_ACK, 16'hFFFE, AIM_RAW);

        // clamped slides, cap below limit, then total shrunk mid-transfer
        add_drain();
        add_cfg(CFG_TOTAL, 16'd40);
        add_cfg(CFG_LENGTH, 16'd32);
        add_cfg(CFG_T_START, 16'd1);
        add_cfg(CFG_T_STEP, 16'd200);
        add_cfg(CFG_T_CAP, 16'd3);
        add_item(CMD_START, 16'h0000, AIM_RAW);
        add_item(CMD_ACK, 16'd20, AIM_RAW);
        add_item(CMD_ACK, 16'd25, AIM_RAW);
        add_item(CMD_OTHER, 16'h1234, AIM_RAW);
        add_item(CMD_SPARE, 16'h8001, AIM_RAW);
        add_drain();
        add_cfg(CFG_TOTAL, 16'd10);
        repeat (4) add_item(CMD_OTHER, 16'h00FF, AIM_RAW);
        add_item(CMD_ACK, 16'd9, AIM_RAW);
        directed_items = items_planned;

        // random phases: new settings, mostly a transfer driven to progress
        while (items_planned - directed_items < RANDOM_ITEMS)
        begin
            add_drain();
            roll = $urandom_range(0, 9);
            if (roll < 6)
                v = 16'($urandom_range(1, 70));
            else if (roll == 6)
                v = 16'($urandom_range(0, 3));
            else if (roll == 7)
                v = 16'hFFFF;
            else
                v = 16'($urandom);
            add_cfg(CFG_TOTAL, v);
            if ($urandom_range(0, 2) != 0)
                add_cfg(CFG_LENGTH, $urandom_range(0, 1) ? 16'($urandom)
                                                         : 16'($urandom_range(1, 8)));
            if ($urandom_range(0, 2) != 0)
                add_cfg(CFG_T_START, $urandom_range(0, 3) ? 16'($urandom_range(0, 8))
                                                          : 16'($urandom));
            if ($urandom_range(0, 2) != 0)
                add_cfg(CFG_T_STEP, 16'($urandom));
            if ($urandom_range(0, 2) != 0)
                add_cfg(CFG_T_CAP, $urandom_range(0, 1) ? 16'($urandom_range(0, 20))
                                                        : 16'($urandom));
            if ($urandom_range(0, 9) == 0)
                add_cfg(CFG_IDX_W'(CFG_SPARE_LO + $urandom_range(0, 2)), 16'($urandom));
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    add_item(2'(CMD_ACK + $urandom_range(0, 2)), 16'($urandom), AIM_RAW);
            // now and then carry on with the old transfer under new settings
            if ($urandom_range(0, 3) != 0)
                add_item(CMD_START, 16'($urandom), AIM_RAW);
            span  = $urandom_range(6, 22);
            ended = 1'b0;
            for (k = 0; k < span && !ended; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    add_item(CMD_ACK, 16'($urandom), AIM_IN_WINDOW);
                else if (roll < 58)
                    add_item(CMD_ACK, 16'($urandom), AIM_WIN_LAST);
                else if (roll < 64)
                begin
                    add_item(CMD_ACK, 16'h0000, AIM_FINAL);
                    ended = 1'b1;
                end
                else if (roll < 78)
                    add_item($urandom_range(0, 1) ? CMD_OTHER : CMD_SPARE, 16'($urandom),
                             AIM_RAW);
                else if (roll < 86)
                    add_item(CMD_ACK, 16'($urandom), AIM_BELOW);
                else if (roll < 95)
                    add_item(CMD_ACK, 16'($urandom), AIM_RAW);
                else
                    add_item(CMD_START, 16'($urandom), AIM_RAW);
            end
        end

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for all stimulus, then all sends, then let the block settle
        while (jobs.size() != 0 || in_valid || cfg_valid)
            @(posedge clk);
        while (sends_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES + 8) @(posedge clk);

        $display("Run covered %0d messages and %0d register writes over %0d setting phases.",
                 items_taken, cfg_taken, phase_count);
        $display("Checked %0d sends: %0d transfers finished, %0d timeout resends, %0d errors.",
                 results_seen, transfers_done, resend_runs, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
